[rtl/epcc_pkg.sv]
// Shared widths and field types for the edge pair contact clipper.
// Used by epcc_div and edge_pair_contact_clipper; depends on nothing.
package epcc_pkg;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 18;
  localparam int RAD_W   = 31;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 51;
  localparam int SPAN_W  = 52;
  localparam int MAG_W   = 51;
  localparam int OFF_W   = 49;
  localparam int DIFF_W  = 33;
  localparam int PP_W    = 51;
  localparam int PEN_W   = 52;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic [RAD_W-1:0]          rad_t;
  typedef logic [MAG_W-1:0]          mag_t;

  typedef struct packed {
    logic zero;
    mag_t num;
    mag_t den;
  } div_req_t;

endpackage

[rtl/epcc_div.sv]
// Pipelined restoring divider giving a lerp ratio clamped to 0..1.
// Depends on epcc_pkg.
module epcc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  epcc_pkg::div_req_t req,
  output logic [FRAC_BITS:0] ratio
);
  import epcc_pkg::*;

  localparam int NS = (FRAC_BITS + 1) / 2;
  localparam int QW = FRAC_BITS + 1;

  mag_t                 rr [NS+1];
  mag_t                 dd [NS+1];
  logic [FRAC_BITS-1:0] qq [NS+1];
  logic                 zz [NS+1];
  logic                 oo [NS+1];

  always_ff @(posedge clk) begin
    rr[0] <= req.num;
    dd[0] <= req.den;
    qq[0] <= '0;
    zz[0] <= req.zero;
    oo[0] <= !req.zero && (req.num >= req.den);
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    mag_t                 rc;
    logic [FRAC_BITS-1:0] qc;
    logic [MAG_W:0]       rw;

    always_comb begin
      rc = rr[s];
      qc = qq[s];
      rw = '0;
      for (int i = 0; i < 2; i++) begin
        if (2 * s + i < FRAC_BITS) begin
          rw = {rc, 1'b0};
          qc = qc << 1;
          if (rw >= {1'b0, dd[s]}) begin
            rw = rw - {1'b0, dd[s]};
            qc[0] = 1'b1;
          end
          rc = rw[MAG_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      rr[s+1] <= rc;
      qq[s+1] <= qc;
      dd[s+1] <= dd[s];
      zz[s+1] <= zz[s];
      oo[s+1] <= oo[s];
    end
  end

  always_comb begin
    if (zz[NS]) begin
      ratio = '0;
    end else if (oo[NS]) begin
      ratio = QW'(1) << FRAC_BITS;
    end else begin
      ratio = {1'b0, qq[NS]};
    end
  end

endmodule

[rtl/edge_pair_contact_clipper.sv]
// Edge pair contact clipper: two 2D edges, a normal and two radii in, up to two contact pairs out.
// One request is taken every cycle while busy is low;
// the ratio dividers are fully pipelined, two steps per stage.
// Results appear for one cycle under done and cannot be held off by the receiver.
// A synchronous reset clears the valid bits; busy is a registered copy of rst.
// Depends on epcc_pkg and epcc_div.
module edge_pair_contact_clipper #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  epcc_pkg::coord_t  edge_a_start_x,
  input  epcc_pkg::coord_t  edge_a_start_y,
  input  epcc_pkg::coord_t  edge_a_end_x,
  input  epcc_pkg::coord_t  edge_a_end_y,
  input  epcc_pkg::coord_t  edge_b_start_x,
  input  epcc_pkg::coord_t  edge_b_start_y,
  input  epcc_pkg::coord_t  edge_b_end_x,
  input  epcc_pkg::coord_t  edge_b_end_y,
  input  epcc_pkg::norm_t   unit_normal_x,
  input  epcc_pkg::norm_t   unit_normal_y,
  input  epcc_pkg::rad_t    radius_first,
  input  epcc_pkg::rad_t    radius_second,
  output logic              done,
  output logic [1:0]        contact_count,
  output epcc_pkg::coord_t  slot0_first_x,
  output epcc_pkg::coord_t  slot0_first_y,
  output epcc_pkg::coord_t  slot0_second_x,
  output epcc_pkg::coord_t  slot0_second_y,
  output epcc_pkg::coord_t  slot1_first_x,
  output epcc_pkg::coord_t  slot1_first_y,
  output epcc_pkg::coord_t  slot1_second_x,
  output epcc_pkg::coord_t  slot1_second_y,
  output epcc_pkg::norm_t   normal_out_x,
  output epcc_pkg::norm_t   normal_out_y
);
  import epcc_pkg::*;

  localparam int QW      = FRAC_BITS + 1;
  localparam int DIV_LAT = (FRAC_BITS + 1) / 2 + 1;
  localparam int LP_W    = DIFF_W + FRAC_BITS + 2;
  localparam int PT_W    = LP_W + 2;
  localparam int LAT     = 8 + DIV_LAT;

  typedef struct packed {
    logic [3:0][COORD_W-1:0] base;
    logic [3:0][DIFF_W-1:0]  span;
    logic [3:0][OFF_W-1:0]   off;
    logic [NORM_W-1:0]       nx;
    logic [NORM_W-1:0]       ny;
  } carry_t;

  function automatic coord_t saturate(input logic signed [PT_W-1:0] v);
    if (v > $signed(PT_W'(32'h7fff_ffff))) begin
      return 32'sh7fff_ffff;
    end else if (v < -$signed(PT_W'(33'h0_8000_0000))) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  coord_t px [4];
  coord_t py [4];
  assign px[0] = edge_a_start_x;
  assign py[0] = edge_a_start_y;
  assign px[1] = edge_a_end_x;
  assign py[1] = edge_a_end_y;
  assign px[2] = edge_b_start_x;
  assign py[2] = edge_b_start_y;
  assign px[3] = edge_b_end_x;
  assign py[3] = edge_b_end_y;

  // Stage 1: projection and offset products.
  logic                      v1;
  carry_t                    c1;
  logic signed [PROD_W-1:0]  xp1 [8];

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      xp1[2*p]   <= PROD_W'(px[p]) * PROD_W'(unit_normal_y);
      xp1[2*p+1] <= PROD_W'(py[p]) * PROD_W'(unit_normal_x);
    end
    c1.base[0] <= edge_a_start_x;
    c1.base[1] <= edge_a_start_y;
    c1.base[2] <= edge_b_start_x;
    c1.base[3] <= edge_b_start_y;
    c1.span[0] <= DIFF_W'(edge_a_end_x) - DIFF_W'(edge_a_start_x);
    c1.span[1] <= DIFF_W'(edge_a_end_y) - DIFF_W'(edge_a_start_y);
    c1.span[2] <= DIFF_W'(edge_b_end_x) - DIFF_W'(edge_b_start_x);
    c1.span[3] <= DIFF_W'(edge_b_end_y) - DIFF_W'(edge_b_start_y);
    c1.off[0]  <= OFF_W'(unit_normal_x) * $signed(OFF_W'(radius_first));
    c1.off[1]  <= OFF_W'(unit_normal_y) * $signed(OFF_W'(radius_first));
    c1.off[2]  <= -(OFF_W'(unit_normal_x) * $signed(OFF_W'(radius_second)));
    c1.off[3]  <= -(OFF_W'(unit_normal_y) * $signed(OFF_W'(radius_second)));
    c1.nx      <= unit_normal_x;
    c1.ny      <= unit_normal_y;
  end

  // Stage 2: tangent projections and floored offsets.
  logic                      v2;
  carry_t                    c2;
  logic signed [CROSS_W-1:0] cr2 [4];

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      cr2[p] <= CROSS_W'(xp1[2*p]) - CROSS_W'(xp1[2*p+1]);
    end
    c2.base <= c1.base;
    c2.span <= c1.span;
    c2.nx   <= c1.nx;
    c2.ny   <= c1.ny;
    for (int f = 0; f < 4; f++) begin
      c2.off[f] <= $signed(c1.off[f]) >>> FRAC_BITS;
    end
  end

  // Stage 3: ratio numerators and denominators.
  logic                      v3;
  carry_t                    c3;
  logic signed [SPAN_W-1:0]  num3 [4];
  logic signed [SPAN_W-1:0]  den3 [4];

  always_ff @(posedge clk) begin
    num3[0] <= SPAN_W'(cr2[3]) - SPAN_W'(cr2[0]);
    num3[1] <= SPAN_W'(cr2[0]) - SPAN_W'(cr2[2]);
    num3[2] <= SPAN_W'(cr2[2]) - SPAN_W'(cr2[0]);
    num3[3] <= SPAN_W'(cr2[1]) - SPAN_W'(cr2[2]);
    den3[0] <= SPAN_W'(cr2[1]) - SPAN_W'(cr2[0]);
    den3[1] <= SPAN_W'(cr2[3]) - SPAN_W'(cr2[2]);
    den3[2] <= SPAN_W'(cr2[1]) - SPAN_W'(cr2[0]);
    den3[3] <= SPAN_W'(cr2[3]) - SPAN_W'(cr2[2]);
    c3 <= c2;
  end

  // Stage 4: magnitudes and the zero cases of each ratio.
  logic                      v4;
  carry_t                    c4;
  div_req_t                  req4 [4];
  logic [QW-1:0]             ratio [4];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      req4[r].zero <= (den3[r] == '0) || (num3[r] == '0) ||
                      (num3[r][SPAN_W-1] != den3[r][SPAN_W-1]);
      req4[r].num  <= num3[r][SPAN_W-1] ? MAG_W'(-num3[r]) : MAG_W'(num3[r]);
      req4[r].den  <= den3[r][SPAN_W-1] ? MAG_W'(-den3[r]) : MAG_W'(den3[r]);
    end
    c4 <= c3;
  end

  for (genvar r = 0; r < 4; r++) begin : g_div
    epcc_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .req   (req4[r]),
      .ratio (ratio[r])
    );
  end

  carry_t cdl [DIV_LAT];
  logic   vdl [DIV_LAT];

  always_ff @(posedge clk) begin
    cdl[0] <= c4;
    for (int i = 1; i < DIV_LAT; i++) begin
      cdl[i] <= cdl[i-1];
    end
  end

  // Stage 5: lerp products.
  logic                     v5;
  carry_t                   c5;
  logic signed [LP_W-1:0]   lp5 [8];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      lp5[j] <= LP_W'($signed(cdl[DIV_LAT-1].span[j & 3])) *
                LP_W'($signed({1'b0, ratio[(j >> 2) * 2 + ((j >> 1) & 1)]}));
    end
    c5 <= cdl[DIV_LAT-1];
  end

  // Stage 6: contact points with skin offsets, saturated.
  logic   v6;
  norm_t  nx6, ny6;
  coord_t pt6 [8];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      pt6[j] <= saturate(PT_W'($signed(c5.base[j & 3])) + PT_W'(lp5[j] >>> FRAC_BITS) +
                         PT_W'($signed(c5.off[j & 3])));
    end
    nx6 <= c5.nx;
    ny6 <= c5.ny;
  end

  // Stage 7: penetration products.
  logic                   v7;
  norm_t                  nx7, ny7;
  coord_t                 pt7 [8];
  logic signed [PP_W-1:0] pp7 [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      pp7[2*k]   <= (PP_W'(pt6[4*k])   - PP_W'(pt6[4*k+2])) * PP_W'(nx6);
      pp7[2*k+1] <= (PP_W'(pt6[4*k+1]) - PP_W'(pt6[4*k+3])) * PP_W'(ny6);
    end
    pt7 <= pt6;
    nx7 <= nx6;
    ny7 <= ny6;
  end

  // Stage 8: keep tests and slot packing.
  logic signed [PEN_W-1:0] pen0, pen1;
  logic                    keep0, keep1;
  coord_t                  s0 [4];
  coord_t                  s1 [4];

  always_comb begin
    pen0  = PEN_W'(pp7[0]) + PEN_W'(pp7[1]);
    pen1  = PEN_W'(pp7[2]) + PEN_W'(pp7[3]);
    keep0 = (pen0 != '0) && !pen0[PEN_W-1];
    keep1 = !pen1[PEN_W-1];
    for (int f = 0; f < 4; f++) begin
      if (keep0) begin
        s0[f] = pt7[f];
      end else if (keep1) begin
        s0[f] = pt7[4+f];
      end else begin
        s0[f] = '0;
      end
      s1[f] = (keep0 && keep1) ? pt7[4+f] : '0;
    end
  end

  always_ff @(posedge clk) begin
    contact_count  <= {1'b0, keep0} + {1'b0, keep1};
    slot0_first_x  <= s0[0];
    slot0_first_y  <= s0[1];
    slot0_second_x <= s0[2];
    slot0_second_y <= s0[3];
    slot1_first_x  <= s1[0];
    slot1_first_y  <= s1[1];
    slot1_second_x <= s1[2];
    slot1_second_y <= s1[3];
    normal_out_x   <= nx7;
    normal_out_y   <= ny7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vdl[i] <= 1'b0;
      end
    end else begin
      v1     <= accept;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      vdl[0] <= v4;
      for (int i = 1; i < DIV_LAT; i++) begin
        vdl[i] <= vdl[i-1];
      end
      v5   <= vdl[DIV_LAT-1];
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    done |-> contact_count <= 2'd2)
    else $error("contact count out of range");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted request did not complete after the pipeline latency");

  a_slot1_clear : assert property (@(posedge clk) disable iff (rst)
    done && contact_count != 2'd2 |-> slot1_first_x == '0 && slot1_first_y == '0 &&
      slot1_second_x == '0 && slot1_second_y == '0)
    else $error("unused second slot is not zero");

  a_slot0_clear : assert property (@(posedge clk) disable iff (rst)
    done && contact_count == 2'd0 |-> slot0_first_x == '0 && slot0_first_y == '0 &&
      slot0_second_x == '0 && slot0_second_y == '0)
    else $error("unused first slot is not zero");

endmodule
